// ===== src/gro_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gro_pkg
// Shared constants and types of the glyph row outline renderer.
// ---------------------------------------------------------------------------
package gro_pkg;

   localparam int GLYPH_SIZE = 16;
   localparam int MAX_CHARS  = 64;
   localparam int ROW_W      = (GLYPH_SIZE < 16) ? GLYPH_SIZE : 16;
   localparam int COL_W      = $clog2(ROW_W);
   localparam int RNUM_W     = 5;
   localparam int SLOT_W     = 6;
   localparam int LEVEL_W    = 8;
   localparam int PROW_W     = 4;
   localparam int PCOL_W     = 10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEVEL_W-1:0] OUTLINE_LEVEL_RAW = 8'h8a;
   localparam logic [LEVEL_W-1:0] LEVEL_MASK_1555   = 8'h1f;

   localparam logic [1:0] CSR_FG_LEVEL     = 2'd0;
   localparam logic [1:0] CSR_BG_LEVEL     = 2'd1;
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd2;
   localparam logic [1:0] CSR_ROTATE       = 2'd3;

   // one row waiting to be drawn, with its neighbors
   typedef struct packed {
      logic [ROW_W-1:0]  cur;
      logic [ROW_W-1:0]  up;
      logic [ROW_W-1:0]  down;
      logic [SLOT_W-1:0] slot;
      logic [RNUM_W-1:0] rnum;
      logic              last;
   } gro_job_type;

   typedef struct packed {
      logic        first_valid;
      logic        second_valid;
      gro_job_type first;
      gro_job_type second;
   } gro_push_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] fg_level;
      logic [LEVEL_W-1:0] bg_level;
      logic               pixel_format;
      logic               rotate;
   } gro_cfg_type;

endpackage
`default_nettype wire

// ===== src/gro_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gro_front
// Takes glyph rows, tracks the row above and the pending row, and turns each
// word into zero, one or two row jobs for the drawing side.
// ---------------------------------------------------------------------------
module gro_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [gro_pkg::ROW_W-1:0]    row_bits,
   input  wire logic [gro_pkg::SLOT_W-1:0]   char_slot,
   input  wire logic                         last_row,
   output gro_pkg::gro_push_type             push
);

   logic [gro_pkg::ROW_W-1:0]  row_above_ff, row_above_in;
   logic [gro_pkg::ROW_W-1:0]  row_pending_ff, row_pending_in;
   logic                       pending_valid_ff, pending_valid_in;
   logic [gro_pkg::RNUM_W-1:0] row_number_ff, row_number_in;
   logic [gro_pkg::SLOT_W-1:0] pending_slot_ff, pending_slot_in;

   gro_pkg::gro_job_type job_pend;
   gro_pkg::gro_job_type job_new;
   logic [gro_pkg::RNUM_W-1:0] rnum_next;
   logic [gro_pkg::ROW_W-1:0]  above_for_new;

   always_comb begin
      rnum_next     = pending_valid_ff ? (row_number_ff + 1'b1) : row_number_ff;
      above_for_new = pending_valid_ff ? row_pending_ff : '0;

      job_pend.cur  = row_pending_ff;
      job_pend.up   = row_above_ff;
      job_pend.down = row_bits;
      job_pend.slot = pending_slot_ff;
      job_pend.rnum = row_number_ff;
      job_pend.last = ~last_row;

      job_new.cur   = row_bits;
      job_new.up    = above_for_new;
      job_new.down  = '0;
      job_new.slot  = char_slot;
      job_new.rnum  = rnum_next;
      job_new.last  = 1'b1;

      // pending row job goes first; the closing row follows it
      push.first_valid  = accept & (pending_valid_ff | last_row);
      push.second_valid = accept & pending_valid_ff & last_row;
      push.first        = pending_valid_ff ? job_pend : job_new;
      push.second       = job_new;

      row_above_in     = row_above_ff;
      row_pending_in   = row_pending_ff;
      pending_valid_in = pending_valid_ff;
      row_number_in    = row_number_ff;
      pending_slot_in  = pending_slot_ff;
      if (accept) begin
         if (last_row) begin
            row_above_in     = '0;
            row_pending_in   = '0;
            pending_valid_in = 1'b0;
            row_number_in    = '0;
            pending_slot_in  = '0;
         end else begin
            row_above_in     = above_for_new;
            row_pending_in   = row_bits;
            pending_valid_in = 1'b1;
            row_number_in    = rnum_next;
            pending_slot_in  = char_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_above_ff     <= '0;
         row_pending_ff   <= '0;
         pending_valid_ff <= 1'b0;
         row_number_ff    <= '0;
         pending_slot_ff  <= '0;
      end else begin
         row_above_ff     <= row_above_in;
         row_pending_ff   <= row_pending_in;
         pending_valid_ff <= pending_valid_in;
         row_number_ff    <= row_number_in;
         pending_slot_ff  <= pending_slot_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/gro_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gro_queue
// Short job queue between front and back; takes up to two jobs a cycle and
// hands out one.
// ---------------------------------------------------------------------------
module gro_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  gro_pkg::gro_push_type      push,
   input  wire logic                  pop,
   output gro_pkg::gro_job_type       head,
   output logic                       not_empty,
   output logic                       room_for_two
);

   gro_pkg::gro_job_type entries_ff [gro_pkg::QUEUE_DEPTH];

   logic [gro_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gro_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gro_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [gro_pkg::QPTR_W-1:0] wr_ptr_plus1;
   logic [gro_pkg::QCNT_W-1:0] push_count;

   assign head         = entries_ff[rd_ptr_ff];
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= gro_pkg::QCNT_W'(gro_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_plus1 = wr_ptr_ff + 1'b1;
      push_count   = gro_pkg::QCNT_W'(push.first_valid) + gro_pkg::QCNT_W'(push.second_valid);
      wr_ptr_in    = wr_ptr_ff + gro_pkg::QPTR_W'(push_count);
      rd_ptr_in    = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff + push_count - gro_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entries_ff[wr_ptr_plus1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= gro_pkg::QCNT_W'(gro_pkg::QUEUE_DEPTH))
      else $error("job queue count beyond depth");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job queue popped while empty");

   a_second_needs_first : assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> (push.first_valid && room_for_two))
      else $error("second job pushed without first or without room");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (count_ff != gro_pkg::QCNT_W'(gro_pkg::QUEUE_DEPTH)) |->
         (gro_pkg::QPTR_W'(wr_ptr_ff - rd_ptr_ff) == gro_pkg::QPTR_W'(count_ff)))
      else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== src/gro_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gro_back
// Draws the job at the queue head, one pixel a cycle while rsp_stall is low,
// into the output register.
// ---------------------------------------------------------------------------
module gro_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  gro_pkg::gro_cfg_type               cfg,
   input  gro_pkg::gro_job_type               job,
   input  wire logic                          job_valid,
   output logic                               job_done,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gro_pkg::LEVEL_W-1:0]        rsp_level,
   output logic                               rsp_alpha,
   output logic [gro_pkg::PROW_W-1:0]         rsp_pixel_row,
   output logic [gro_pkg::PCOL_W-1:0]         rsp_pixel_col,
   output logic                               rsp_run_end
);

   localparam logic [gro_pkg::COL_W-1:0] LAST_COL = gro_pkg::COL_W'(gro_pkg::ROW_W - 1);

   logic [gro_pkg::COL_W-1:0] col_ff, col_in;
   logic                      valid_ff, valid_in;
   logic [gro_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                      alpha_ff, alpha_in;
   logic [gro_pkg::PROW_W-1:0] prow_ff, prow_in;
   logic [gro_pkg::PCOL_W-1:0] pcol_ff, pcol_in;
   logic                      run_end_ff, run_end_in;

   logic                      advance;
   logic [gro_pkg::COL_W-1:0] idx;
   logic                      cur_bit, left_bit, right_bit, edge_px;
   logic [2:0]                k;
   logic [gro_pkg::RNUM_W-1:0] rflip;

   always_comb begin
      advance   = job_valid & (~valid_ff | ~rsp_stall);
      job_done  = advance & (col_ff == LAST_COL);

      // column 0 is the most significant bit
      idx       = LAST_COL - col_ff;
      k         = col_ff[2:0];
      cur_bit   = job.cur[idx];
      left_bit  = (k != 3'd0) & job.cur[gro_pkg::COL_W'(idx + 1'b1)];
      right_bit = (k != 3'd7) & job.cur[gro_pkg::COL_W'(idx - 1'b1)];
      edge_px   = left_bit | right_bit | job.up[idx] | job.down[idx];

      if (cur_bit) begin
         level_in = cfg.pixel_format ? (cfg.fg_level & gro_pkg::LEVEL_MASK_1555)
                                     : cfg.fg_level;
         alpha_in = cfg.pixel_format;
      end else if (cfg.pixel_format) begin
         level_in = edge_px ? (gro_pkg::OUTLINE_LEVEL_RAW & gro_pkg::LEVEL_MASK_1555)
                            : (cfg.bg_level & gro_pkg::LEVEL_MASK_1555);
         alpha_in = edge_px;
      end else begin
         level_in = cfg.bg_level;
         alpha_in = 1'b0;
      end

      rflip      = gro_pkg::RNUM_W'(gro_pkg::GLYPH_SIZE - 1) - job.rnum;
      prow_in    = cfg.rotate ? rflip[gro_pkg::PROW_W-1:0] : job.rnum[gro_pkg::PROW_W-1:0];
      pcol_in    = gro_pkg::PCOL_W'(job.slot * gro_pkg::GLYPH_SIZE + col_ff);
      run_end_in = job.last & (col_ff == LAST_COL);

      col_in   = col_ff;
      valid_in = valid_ff;
      if (advance) begin
         col_in   = (col_ff == LAST_COL) ? '0 : (col_ff + 1'b1);
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff   <= level_in;
         alpha_ff   <= alpha_in;
         prow_ff    <= prow_in;
         pcol_ff    <= pcol_in;
         run_end_ff <= run_end_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_level     = level_ff;
   assign rsp_alpha     = alpha_ff;
   assign rsp_pixel_row = prow_ff;
   assign rsp_pixel_col = pcol_ff;
   assign rsp_run_end   = run_end_ff;

endmodule
`default_nettype wire

// ===== src/glyph_row_outline_renderer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// glyph_row_outline_renderer
// Renders glyph rows as gray or 1555 pixels; 1555 adds a one-pixel outline.
// ---------------------------------------------------------------------------
// Each row word is drawn once the row below it has arrived, so a word gives
// no pixels when it opens a glyph of more than one row, 16 pixels, or 32
// pixels when it closes a glyph of two or more rows; run_end marks the last
// pixel of each word. The drawing side puts out one pixel per cycle while
// rsp_stall is low. A queue of four row jobs sits between the row tracker
// and the drawing side; a row word is taken whenever two job slots are free,
// so several words may be taken while earlier rows are still being drawn.
// Configuration writes are always ready and should only be made while the
// block is idle.
module glyph_row_outline_renderer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [15:0]                   req_row_bits,
   input  wire logic [gro_pkg::SLOT_W-1:0]    req_char_slot,
   input  wire logic                          req_last_row,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gro_pkg::LEVEL_W-1:0]        rsp_level,
   output logic                               rsp_alpha,
   output logic [gro_pkg::PROW_W-1:0]         rsp_pixel_row,
   output logic [gro_pkg::PCOL_W-1:0]         rsp_pixel_col,
   output logic                               rsp_run_end,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [7:0]                    csr_data
);

   gro_pkg::gro_cfg_type  cfg_ff, cfg_in;
   gro_pkg::gro_push_type push;
   gro_pkg::gro_job_type  head;
   logic                  not_empty;
   logic                  room_for_two;
   logic                  job_done;
   logic                  req_accept;
   logic [gro_pkg::ROW_W-1:0]  row_masked;
   logic [gro_pkg::SLOT_W-1:0] slot_wrapped;

   assign csr_ready    = 1'b1;
   assign req_stall    = ~room_for_two;
   assign req_accept   = req_valid & ~req_stall;
   assign row_masked   = req_row_bits[gro_pkg::ROW_W-1:0];
   assign slot_wrapped = gro_pkg::SLOT_W'(req_char_slot % gro_pkg::MAX_CHARS);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid & csr_ready) begin
         case (csr_index)
            gro_pkg::CSR_FG_LEVEL:     cfg_in.fg_level     = csr_data;
            gro_pkg::CSR_BG_LEVEL:     cfg_in.bg_level     = csr_data;
            gro_pkg::CSR_PIXEL_FORMAT: cfg_in.pixel_format = csr_data[0];
            gro_pkg::CSR_ROTATE:       cfg_in.rotate       = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_level     <= 8'hff;
         cfg_ff.bg_level     <= 8'h00;
         cfg_ff.pixel_format <= 1'b0;
         cfg_ff.rotate       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gro_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .row_bits  (row_masked),
      .char_slot (slot_wrapped),
      .last_row  (req_last_row),
      .push      (push)
   );

   gro_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (job_done),
      .head         (head),
      .not_empty    (not_empty),
      .room_for_two (room_for_two)
   );

   gro_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .job           (head),
      .job_valid     (not_empty),
      .job_done      (job_done),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_alpha     (rsp_alpha),
      .rsp_pixel_row (rsp_pixel_row),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_run_end   (rsp_run_end)
   );

endmodule
`default_nettype wire

// ===== dv/glyph_row_outline_renderer_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_row_outline_renderer_tb
// Self-checking bench for the glyph row renderer. Glyph row words go in
// through a queue-fed driver. A monitor predicts the pixels of each accepted
// word and checks every returned pixel against the oldest prediction. Runs
// several register settings and three idle mixes, plus one long output hold.
// ---------------------------------------------------------------------------
module glyph_row_outline_renderer_tb;

   typedef struct packed {
      logic [15:0]                bits;
      logic [gro_pkg::SLOT_W-1:0] slot;
      logic                       last;
   } row_word_type;

   typedef struct packed {
      logic [gro_pkg::LEVEL_W-1:0] level;
      logic                        alpha;
      logic [gro_pkg::PROW_W-1:0]  prow;
      logic [gro_pkg::PCOL_W-1:0]  pcol;
      logic                        run_end;
   } pixel_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [15:0]                  req_row_bits = '0;
   logic [gro_pkg::SLOT_W-1:0]   req_char_slot = '0;
   logic                         req_last_row = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [gro_pkg::LEVEL_W-1:0]  rsp_level;
   logic                         rsp_alpha;
   logic [gro_pkg::PROW_W-1:0]   rsp_pixel_row;
   logic [gro_pkg::PCOL_W-1:0]   rsp_pixel_col;
   logic                         rsp_run_end;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [1:0]                   csr_index = '0;
   logic [7:0]                   csr_data = '0;

   row_word_type row_q[$];
   pixel_type    pixel_q[$];
   logic         req_fire = 1'b0;
   logic         rx_hold = 1'b0;
   logic         hold_go = 1'b0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           fail_count = 0;

   // predictor state
   gro_pkg::gro_cfg_type        shadow_cfg = '{fg_level: 8'hff, bg_level: 8'h00,
                                               pixel_format: 1'b0, rotate: 1'b0};
   logic [15:0]                 above_row = '0;
   logic [15:0]                 held_row = '0;
   logic                        held_valid = 1'b0;
   logic [gro_pkg::SLOT_W-1:0]  held_slot = '0;
   logic [gro_pkg::RNUM_W-1:0]  next_rnum = '0;

   glyph_row_outline_renderer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row_bits  (req_row_bits),
      .req_char_slot (req_char_slot),
      .req_last_row  (req_last_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_alpha     (rsp_alpha),
      .rsp_pixel_row (rsp_pixel_row),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_run_end   (rsp_run_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // pixels of one row, using the column neighbors inside its byte
   task automatic draw_row(input logic [15:0] cur, input logic [15:0] up,
                           input logic [15:0] down,
                           input logic [gro_pkg::SLOT_W-1:0] slot);
      pixel_type px;
      int        c;
      int        b;
      logic      left;
      logic      right;
      logic      near;
      for (c = 0; c < gro_pkg::ROW_W; c++) begin
         b = gro_pkg::ROW_W - 1 - c;
         px = '0;
         if (cur[b]) begin
            px.level = shadow_cfg.pixel_format
                       ? (shadow_cfg.fg_level & gro_pkg::LEVEL_MASK_1555)
                       : shadow_cfg.fg_level;
            px.alpha = shadow_cfg.pixel_format;
         end else begin
            left  = (c % 8 != 0) ? cur[b+1] : 1'b0;
            right = (c % 8 != 7) ? cur[b-1] : 1'b0;
            near  = left || right || up[b] || down[b];
            if (shadow_cfg.pixel_format) begin
               px.level = near ? (gro_pkg::OUTLINE_LEVEL_RAW & gro_pkg::LEVEL_MASK_1555)
                               : (shadow_cfg.bg_level & gro_pkg::LEVEL_MASK_1555);
               px.alpha = near;
            end else begin
               px.level = shadow_cfg.bg_level;
               px.alpha = 1'b0;
            end
         end
         px.prow = shadow_cfg.rotate
                   ? gro_pkg::PROW_W'(gro_pkg::GLYPH_SIZE - 1 - int'(next_rnum))
                   : next_rnum[gro_pkg::PROW_W-1:0];
         px.pcol = gro_pkg::PCOL_W'(int'(slot) * gro_pkg::GLYPH_SIZE + c);
         pixel_q.push_back(px);
      end
      next_rnum = next_rnum + 1'b1;
   endtask

   task automatic take_row(input logic [15:0] bits,
                           input logic [gro_pkg::SLOT_W-1:0] slot,
                           input logic last);
      int        queued;
      pixel_type tail;
      queued = pixel_q.size();
      if (held_valid) begin
         draw_row(held_row, above_row, bits, held_slot);
         above_row = held_row;
      end else begin
         above_row = '0;
      end
      held_row   = bits;
      held_slot  = slot;
      held_valid = 1'b1;
      // closing row is drawn against an empty row below
      if (last) begin
         draw_row(held_row, above_row, '0, held_slot);
         above_row  = '0;
         held_row   = '0;
         held_valid = 1'b0;
         held_slot  = '0;
         next_rnum  = '0;
      end
      if (pixel_q.size() > queued) begin
         tail = pixel_q.pop_back();
         tail.run_end = 1'b1;
         pixel_q.push_back(tail);
      end
   endtask

   // word driver
   always @(negedge clock) begin : drive_rows
      row_word_type w;
      if (!reset && (!req_valid || req_fire)) begin
         if (row_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            w = row_q.pop_front();
            req_valid     <= 1'b1;
            req_row_bits  <= w.bits;
            req_char_slot <= w.slot;
            req_last_row  <= w.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= rx_hold || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // monitor: predict on accepted words, check accepted pixels
   always @(posedge clock) begin : watch
      pixel_type want;
      pixel_type got;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         take_row(req_row_bits, req_char_slot, req_last_row);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{level: rsp_level, alpha: rsp_alpha, prow: rsp_pixel_row,
                 pcol: rsp_pixel_col, run_end: rsp_run_end};
         if (pixel_q.size() == 0) begin
            if (fail_count < 10) begin
               $display("%0t: pixel with none expected: level %0h col %0d", $realtime,
                        rsp_level, rsp_pixel_col);
            end
            fail_count++;
         end else begin
            want = pixel_q.pop_front();
            if (got !== want) begin
               if (fail_count < 10) begin
                  $display("%0t: pixel mismatch (want/got) level %0h/%0h alpha %0b/%0b",
                           $realtime, want.level, got.level, want.alpha, got.alpha);
                  $display("   row %0d/%0d col %0d/%0d run_end %0b/%0b",
                           want.prow, got.prow, want.pcol, got.pcol,
                           want.run_end, got.run_end);
               end
               fail_count++;
            end
         end
      end
   end

   // long output hold so the block fills and stalls its input
   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      rx_hold = 1'b1;
      repeat (400) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gro_pkg::CSR_FG_LEVEL:     shadow_cfg.fg_level = val;
         gro_pkg::CSR_BG_LEVEL:     shadow_cfg.bg_level = val;
         gro_pkg::CSR_PIXEL_FORMAT: shadow_cfg.pixel_format = val[0];
         gro_pkg::CSR_ROTATE:       shadow_cfg.rotate = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] fg, input logic [7:0] bg,
                             input logic fmt, input logic rot);
      write_reg(gro_pkg::CSR_FG_LEVEL, fg);
      write_reg(gro_pkg::CSR_BG_LEVEL, bg);
      write_reg(gro_pkg::CSR_PIXEL_FORMAT, {7'd0, fmt});
      write_reg(gro_pkg::CSR_ROTATE, {7'd0, rot});
   endtask

   task automatic add_word(input logic [15:0] bits,
                           input logic [gro_pkg::SLOT_W-1:0] slot,
                           input logic last);
      row_q.push_back(row_word_type'{bits: bits, slot: slot, last: last});
   endtask

   function automatic logic [15:0] pick_row();
      logic [15:0] one_hot;
      one_hot = 16'h0001 << $urandom_range(0, 15);
      case ($urandom_range(0, 7))
         0: pick_row = '0;
         1: pick_row = '1;
         2: pick_row = one_hot;
         3: pick_row = ~one_hot;
         default: pick_row = 16'($urandom());
      endcase
   endfunction

   task automatic add_glyph(input int rows);
      logic [gro_pkg::SLOT_W-1:0] slot;
      int                         r;
      slot = gro_pkg::SLOT_W'($urandom_range(0, gro_pkg::MAX_CHARS - 1));
      for (r = 0; r < rows; r++) begin
         // now and then a glyph moves to another slot mid-way
         if ($urandom_range(0, 9) == 0) begin
            slot = gro_pkg::SLOT_W'($urandom_range(0, gro_pkg::MAX_CHARS - 1));
         end
         add_word(pick_row(), slot, r == rows - 1);
      end
   endtask

   task automatic queue_glyphs(input int target);
      int goal;
      goal = row_q.size() + target;
      while (row_q.size() < goal) begin
         // some glyphs run past the glyph height so the row count wraps
         if ($urandom_range(0, 99) < 8) add_glyph($urandom_range(17, 40));
         else add_glyph($urandom_range(1, 16));
      end
   endtask

   task automatic settle();
      while (row_q.size() != 0 || req_valid || pixel_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 19;
      recv_idle_pct = 78;

      // directed words, outline visible in 1555 mode
      write_reg(gro_pkg::CSR_PIXEL_FORMAT, 8'd1);
      add_word(16'hffff, 6'd0, 1'b1);
      add_word(16'h0000, 6'd63, 1'b1);
      add_word(16'h0100, 6'd5, 1'b0);
      add_word(16'h0080, 6'd5, 1'b0);
      add_word(16'h8001, 6'd5, 1'b0);
      add_word(16'h0000, 6'd5, 1'b1);
      add_word(16'h1818, 6'd7, 1'b0);
      add_word(16'h2424, 6'd7, 1'b0);
      add_word(16'ha5a5, 6'd7, 1'b1);
      add_word(16'h0ff0, 6'd10, 1'b0);
      add_word(16'hf00f, 6'd11, 1'b0);
      add_word(16'h5555, 6'd12, 1'b1);
      add_word(16'haaaa, 6'd63, 1'b0);
      add_word(16'h5555, 6'd63, 1'b1);
      add_word(16'h7ffe, 6'd1, 1'b1);
      add_word(16'hff00, 6'd20, 1'b0);
      add_word(16'h00ff, 6'd20, 1'b0);
      add_word(16'h0000, 6'd20, 1'b1);
      settle();

      set_config(8'h00, 8'hff, 1'b1, 1'b1);
      queue_glyphs(55);
      settle();

      send_idle_pct = 78;
      recv_idle_pct = 19;
      set_config(8'hc3, 8'h3c, 1'b0, 1'b1);
      queue_glyphs(55);
      settle();

      set_config(8'($urandom()), 8'($urandom()), 1'b1, 1'b0);
      queue_glyphs(55);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'($urandom()), 8'($urandom()), 1'b1, 1'b1);
      queue_glyphs(45);
      hold_go = 1'b1;
      settle();

      set_config(8'hff, 8'h00, 1'b0, 1'b0);
      add_glyph(36);
      queue_glyphs(20);
      settle();

      set_config(8'($urandom()), 8'($urandom()), 1'($urandom()), 1'($urandom()));
      queue_glyphs(30);
      settle();

      fail_count += pixel_q.size();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
